// ----- rtl/ofa_pkg.sv -----
package ofa_pkg;

  localparam int QUEUE_DEPTH = 5;
  localparam int ID_W        = 10;
  localparam int RATE_W      = 8;
  localparam int FILL_W      = 3;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = RATE_W + CNT_W;
  localparam int STEP_W      = $clog2(SUM_W + 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   entry_id;
    logic [RATE_W-1:0] entry_rate;
  } in_req_t;

  typedef struct packed {
    logic [RATE_W-1:0] mean_rate;
    logic              evicted;
    logic [ID_W-1:0]   removed_id;
    logic [RATE_W-1:0] removed_rate;
    logic              was_empty;
    logic [FILL_W-1:0] fill_count;
  } out_res_t;

  typedef struct packed {
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- rtl/ofa_div.sv -----
module ofa_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     div_start,
  input  ofa_pkg::div_req_t        div_req,
  output logic                     div_done,
  output logic [ofa_pkg::RATE_W-1:0] div_quo
);
  import ofa_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W:0]    rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r, quo_r[SUM_W-1]};
    if (div_start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      rem_nxt  = '0;
      quo_nxt  = div_req.dividend;
      dvs_nxt  = div_req.divisor;
    end else if (busy_r) begin
      // one restoring step per cycle
      quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt    = CNT_W'(rem_sh - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = CNT_W'(rem_sh);
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign div_done = done_r;
  assign div_quo  = quo_r[RATE_W-1:0];

endmodule

// ----- rtl/overwrite_fifo_with_average_core.sv -----
// channel   ports                     request accepted when
// input     start, busy, in_req       start high and busy low
// result    out_valid, out_res        out_valid high (one cycle strobe)
//
// a remove result strobes 1 cycle after the accepting edge
// an insert result strobes 13 cycles after it: one update cycle, then the
//   shared restoring divider takes one quotient bit per cycle over the sum width
// busy drops in the strobe cycle, so a new request may be taken there
// synchronous active-low reset empties the queue; the receiver cannot stall
module overwrite_fifo_with_average_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ofa_pkg::in_req_t  in_req,
  output logic              out_valid,
  output ofa_pkg::out_res_t out_res
);
  import ofa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_UPD  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  in_req_t           req_r, req_nxt;
  out_res_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [ID_W-1:0]   id_r   [QUEUE_DEPTH];
  logic [RATE_W-1:0] rate_r [QUEUE_DEPTH];

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  h1;
  logic [CNT_W-1:0]  c1;
  logic [SUM_W-1:0]  s1;
  logic [CNT_W:0]    tail_raw;
  logic              full;
  logic              div_start;
  div_req_t          div_req;
  logic              div_done;
  logic [RATE_W-1:0] div_quo;

  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    head_nxt      = head_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    wr_en         = 1'b0;
    div_start     = 1'b0;
    h1            = full ? head_inc : head_r;
    c1            = full ? count_r - 1'b1 : count_r;
    s1            = full ? sum_r - SUM_W'(rate_r[head_r]) : sum_r;
    tail_raw      = (CNT_W+1)'(h1) + (CNT_W+1)'(c1);
    wr_idx        = (tail_raw >= (CNT_W+1)'(QUEUE_DEPTH))
                    ? IDX_W'(tail_raw - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_raw);
    div_req.dividend = s1 + SUM_W'(req_r.entry_rate);
    div_req.divisor  = c1 + 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        res_nxt = '0;
        if (req_r.kind == KIND_INSERT) begin
          wr_en              = 1'b1;
          head_nxt           = h1;
          count_nxt          = div_req.divisor;
          sum_nxt            = div_req.dividend;
          div_start          = 1'b1;
          res_nxt.evicted    = full;
          res_nxt.fill_count = FILL_W'(div_req.divisor);
          state_nxt          = S_DIV;
        end else begin
          if (count_r == '0) begin
            res_nxt.was_empty = 1'b1;
          end else begin
            res_nxt.removed_id   = id_r[head_r];
            res_nxt.removed_rate = rate_r[head_r];
            head_nxt             = head_inc;
            count_nxt            = count_r - 1'b1;
            sum_nxt              = sum_r - SUM_W'(rate_r[head_r]);
          end
          res_nxt.fill_count = FILL_W'(count_nxt);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_nxt.mean_rate = div_quo;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
    end
    req_r <= req_nxt;
    res_r <= res_nxt;
    if (wr_en) begin
      id_r[wr_idx]   <= req_r.entry_id;
      rate_r[wr_idx] <= req_r.entry_rate;
    end
  end

  ofa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .div_start (div_start),
    .div_req   (div_req),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside divide state");
`endif

endmodule
